>>> rtl/core/pwb_pkg.sv
// Shared types and constants of the perspective warp block.
package pwb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NUMX_AB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMX_C_YA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUMY_BC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_AB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_C     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE = 3'd7;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WARP  = 1'b1;
  localparam logic MODE_CLAMP  = 1'b0;
  localparam logic MODE_MIRROR = 1'b1;

  localparam int COEF_W    = 32;
  localparam int POS_W     = 10;
  localparam int DIM_W     = 11;
  localparam int PIX_W     = 24;
  localparam int PROD_W    = 43;
  localparam int SUM_W     = 45;
  localparam int MAG_W     = 43;
  localparam int NUM_FRAC  = 16;
  localparam int DEN_FRAC  = 24;
  localparam int MIN_DEPTH = 1678;

  localparam logic [63:0]       RESET_NUM_PAIR = 64'h0000_0001_0000_0000;
  localparam logic [COEF_W-1:0] RESET_ONE_Q24  = 32'h0100_0000;
  localparam logic [DIM_W-1:0]  RESET_DIM      = 11'd1024;

  typedef struct packed {
    logic             action;
    logic             fault;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] rgb;
  } item_t;

endpackage

>>> rtl/core/pwb_if.sv
// Input and result channel interfaces of the perspective warp block.
interface pwb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [9:0] pos_x;
  logic [9:0] pos_y;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, in_red, in_green, in_blue,
                  output ready);
endinterface

interface pwb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       depth_fault;

  modport source (output valid, out_red, out_green, out_blue, depth_fault, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, depth_fault, output ready);
endinterface

>>> rtl/core/pwb_ram.sv
// Generic single-port-write, registered-read RAM.
module pwb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/pwb_div.sv
// Pipelined restoring divider, one quotient bit per stage, with running modulo.
module pwb_div #(
  parameter int MAG_W = 43,
  parameter int SHIFT = 16,
  parameter int PW    = 20,
  parameter int TW    = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vin,
  input  logic [MAG_W-1:0]        num,
  input  logic [MAG_W-1:0]        den,
  input  logic [PW-1:0]           modp,
  input  logic [TW-1:0]           tin,
  output logic                    vout,
  output logic [MAG_W+SHIFT-1:0]  quo,
  output logic                    rem_nz,
  output logic [PW-1:0]           modr,
  output logic [TW-1:0]           tout
);

  localparam int NB = MAG_W + SHIFT;

  logic             v_r   [NB];
  logic [MAG_W-1:0] rem_r [NB];
  logic [MAG_W-1:0] den_r [NB];
  logic [NB-1:0]    dq_r  [NB];
  logic [PW-1:0]    md_r  [NB];
  logic [TW-1:0]    tg_r  [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic             v_i;
    logic [MAG_W-1:0] rem_i;
    logic [MAG_W-1:0] den_i;
    logic [NB-1:0]    dq_i;
    logic [PW-1:0]    md_i;
    logic [TW-1:0]    tg_i;
    logic [MAG_W:0]   trial;
    logic [PW:0]      mtrial;
    logic             qbit;
    logic [MAG_W-1:0] rem_nxt;
    logic [PW-1:0]    md_nxt;

    if (k == 0) begin : g_first
      assign v_i   = vin;
      assign rem_i = '0;
      assign den_i = den;
      assign dq_i  = {num, SHIFT'(0)};
      assign md_i  = '0;
      assign tg_i  = tin;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign dq_i  = dq_r[k-1];
      assign md_i  = md_r[k-1];
      assign tg_i  = tg_r[k-1];
    end

    always_comb begin
      trial   = {rem_i, dq_i[NB-1]};
      qbit    = (trial >= {1'b0, den_i});
      rem_nxt = MAG_W'(qbit ? (trial - {1'b0, den_i}) : trial);
      mtrial  = {md_i, qbit};
      md_nxt  = PW'((mtrial >= {1'b0, modp}) ? (mtrial - {1'b0, modp}) : mtrial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_i;
        dq_r[k]  <= {dq_i[NB-2:0], qbit};
        md_r[k]  <= md_nxt;
        tg_r[k]  <= tg_i;
      end
    end
  end

  assign vout   = v_r[NB-1];
  assign quo    = dq_r[NB-1];
  assign rem_nz = |rem_r[NB-1];
  assign modr   = md_r[NB-1];
  assign tout   = tg_r[NB-1];

endmodule

>>> rtl/core/perspective_warp_bilinear_top.sv
// Top level of the projective warp with bilinear RGB sampling.
// The block takes one word per cycle, writes and warps alike, and returns one
// pixel per warp word in order. Most of the pipeline is the one-bit-per-stage
// divider that yields the source point; the whole pipeline holds while a result
// waits. The frame store is four RAM banks split by column and row parity, so
// the four neighbors of a sample are read in the same cycle; writes pass through
// the same pipeline and reach the banks at the read stage, which keeps store
// accesses in word order.
module perspective_warp_bilinear_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pwb_in_if.sink                            in_ch,
  pwb_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CW     = $clog2(MAX_WIDTH) + 1;
  localparam int RW     = $clog2(MAX_HEIGHT) + 1;
  localparam int GW     = (CW > RW) ? CW : RW;
  localparam int FW     = FRAC_BITS;
  localparam int SW     = GW + FW;
  localparam int PW     = SW + 1;
  localparam int SHIFT  = pwb_pkg::DEN_FRAC - pwb_pkg::NUM_FRAC + FRAC_BITS;
  localparam int NB     = pwb_pkg::MAG_W + SHIFT;
  localparam int HW     = (MAX_WIDTH + 1) / 2;
  localparam int HH     = (MAX_HEIGHT + 1) / 2;
  localparam int BDEPTH = HW * HH;
  localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int TVW    = 8 + FW + 1;
  localparam int VW     = TVW + FW + 1;
  localparam int TXW    = $bits(pwb_pkg::item_t) + 1;

  localparam int CDW = pwb_pkg::COEF_W;
  localparam int SUW = pwb_pkg::SUM_W;
  localparam int MGW = pwb_pkg::MAG_W;

  // configuration
  logic [63:0]              numx_ab_r, numx_c_ya_r, numy_bc_r, den_ab_r;
  logic [CDW-1:0]           den_c_r;
  logic [pwb_pkg::DIM_W-1:0] width_r, height_r;
  logic                     mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numx_ab_r   <= pwb_pkg::RESET_NUM_PAIR;
      numx_c_ya_r <= '0;
      numy_bc_r   <= pwb_pkg::RESET_NUM_PAIR;
      den_ab_r    <= '0;
      den_c_r     <= pwb_pkg::RESET_ONE_Q24;
      width_r     <= pwb_pkg::RESET_DIM;
      height_r    <= pwb_pkg::RESET_DIM;
      mode_r      <= pwb_pkg::MODE_CLAMP;
    end else if (cfg_we) begin
      case (cfg_index)
        pwb_pkg::REG_NUMX_AB:   numx_ab_r   <= cfg_wdata;
        pwb_pkg::REG_NUMX_C_YA: numx_c_ya_r <= cfg_wdata;
        pwb_pkg::REG_NUMY_BC:   numy_bc_r   <= cfg_wdata;
        pwb_pkg::REG_DEN_AB:    den_ab_r    <= cfg_wdata;
        pwb_pkg::REG_DEN_C:     den_c_r     <= cfg_wdata[CDW-1:0];
        pwb_pkg::REG_WIDTH:     width_r     <= cfg_wdata[pwb_pkg::DIM_W-1:0];
        pwb_pkg::REG_HEIGHT:    height_r    <= cfg_wdata[pwb_pkg::DIM_W-1:0];
        pwb_pkg::REG_EDGE_MODE: mode_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic signed [CDW-1:0] ax, bx, cx, ay, by, cy, ad, bd, cd;
  assign ax = numx_ab_r[31:0];
  assign bx = numx_ab_r[63:32];
  assign cx = numx_c_ya_r[31:0];
  assign ay = numx_c_ya_r[63:32];
  assign by = numy_bc_r[31:0];
  assign cy = numy_bc_r[63:32];
  assign ad = den_ab_r[31:0];
  assign bd = den_ab_r[63:32];
  assign cd = den_c_r;

  logic          mirror;
  logic [CW-1:0] w_c;
  logic [RW-1:0] h_c;
  logic [SW-1:0] mx, my;
  logic [PW-1:0] px, py;

  assign mirror = (mode_r == pwb_pkg::MODE_MIRROR);

  always_comb begin
    if (width_r < 11'd2) begin
      w_c = CW'(2);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(width_r);
    end
    if (height_r < 11'd2) begin
      h_c = RW'(2);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_c = RW'(MAX_HEIGHT);
    end else begin
      h_c = RW'(height_r);
    end
    mx = SW'(w_c - CW'(1)) << FRAC_BITS;
    my = SW'(h_c - RW'(1)) << FRAC_BITS;
    px = PW'(mx) << 1;
    py = PW'(my) << 1;
  end

  // handshake
  logic adv;
  logic out_valid_r;
  logic accept;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  // stage 1: products
  logic                      s1_valid_r;
  pwb_pkg::item_t            s1_item_r;
  logic signed [pwb_pkg::PROD_W-1:0] s1_axx_r, s1_bxy_r, s1_ayx_r, s1_byy_r, s1_adx_r, s1_bdy_r;
  logic signed [pwb_pkg::POS_W:0]    xs, ys;

  assign xs = {1'b0, in_ch.pos_x};
  assign ys = {1'b0, in_ch.pos_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r.action <= in_ch.action;
      s1_item_r.fault  <= 1'b0;
      s1_item_r.pos_x  <= in_ch.pos_x;
      s1_item_r.pos_y  <= in_ch.pos_y;
      s1_item_r.rgb    <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
      s1_axx_r <= ax * xs;
      s1_bxy_r <= bx * ys;
      s1_ayx_r <= ay * xs;
      s1_byy_r <= by * ys;
      s1_adx_r <= ad * xs;
      s1_bdy_r <= bd * ys;
    end
  end

  // stage 2: sums
  logic                  s2_valid_r;
  pwb_pkg::item_t        s2_item_r;
  logic signed [SUW-1:0] s2_nx_r, s2_ny_r, s2_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r <= s1_item_r;
      s2_nx_r   <= SUW'(s1_axx_r) + SUW'(s1_bxy_r) + SUW'(cx);
      s2_ny_r   <= SUW'(s1_ayx_r) + SUW'(s1_byy_r) + SUW'(cy);
      s2_d_r    <= SUW'(s1_adx_r) + SUW'(s1_bdy_r) + SUW'(cd);
    end
  end

  // stage 3: depth limit and magnitudes
  logic                  s3_valid_r;
  pwb_pkg::item_t        s3_item_r;
  pwb_pkg::item_t        s3_item_c;
  logic [MGW-1:0]        s3_unx_r, s3_uny_r, s3_ud_r;
  logic                  s3_negx_r, s3_negy_r;
  logic signed [SUW-1:0] dadj;
  logic                  dlow;

  always_comb begin
    dlow = (s2_d_r <= pwb_pkg::MIN_DEPTH);
    dadj = s2_d_r;
    if (dlow) begin
      if (mirror && (s2_d_r < 0)) begin
        dadj = (s2_d_r < -pwb_pkg::MIN_DEPTH) ? s2_d_r : SUW'(-pwb_pkg::MIN_DEPTH);
      end else begin
        dadj = SUW'(pwb_pkg::MIN_DEPTH);
      end
    end
    s3_item_c       = s2_item_r;
    s3_item_c.fault = dlow && !mirror;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item_r <= s3_item_c;
      s3_unx_r  <= MGW'((s2_nx_r < 0) ? -s2_nx_r : s2_nx_r);
      s3_uny_r  <= MGW'((s2_ny_r < 0) ? -s2_ny_r : s2_ny_r);
      s3_ud_r   <= MGW'((dadj < 0) ? -dadj : dadj);
      s3_negx_r <= (s2_nx_r < 0) != (dadj < 0);
      s3_negy_r <= (s2_ny_r < 0) != (dadj < 0);
    end
  end

  // divide
  logic           dvx_v, dvy_v;
  logic [NB-1:0]  qx, qy;
  logic           rnzx, rnzy;
  logic [PW-1:0]  rmx, rmy;
  logic [TXW-1:0] tagx;
  logic [0:0]     tagy;

  pwb_div #(.MAG_W(MGW), .SHIFT(SHIFT), .PW(PW), .TW(TXW)) u_div_x (
    .clk, .rst_n, .en(adv), .vin(s3_valid_r),
    .num(s3_unx_r), .den(s3_ud_r), .modp(px), .tin({s3_negx_r, s3_item_r}),
    .vout(dvx_v), .quo(qx), .rem_nz(rnzx), .modr(rmx), .tout(tagx)
  );

  pwb_div #(.MAG_W(MGW), .SHIFT(SHIFT), .PW(PW), .TW(1)) u_div_y (
    .clk, .rst_n, .en(adv), .vin(s3_valid_r),
    .num(s3_uny_r), .den(s3_ud_r), .modp(py), .tin(s3_negy_r),
    .vout(dvy_v), .quo(qy), .rem_nz(rnzy), .modr(rmy), .tout(tagy)
  );

  function automatic logic [SW-1:0] fold(input logic [NB-1:0] q, input logic rnz,
                                         input logic [PW-1:0] rm, input logic neg,
                                         input logic [SW-1:0] m, input logic [PW-1:0] p,
                                         input logic mir);
    logic [PW:0]   t;
    logic [PW-1:0] v;
    logic [SW-1:0] res;
    t = {1'b0, rm} + (PW+1)'(rnz & neg);
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    v = PW'(t);
    if (neg && (v != '0)) begin
      v = p - v;
    end
    if (v > PW'(m)) begin
      v = p - v;
    end
    if (mir) begin
      res = SW'(v);
    end else if (neg) begin
      res = '0;
    end else if (q > NB'(m)) begin
      res = m;
    end else begin
      res = SW'(q);
    end
    return res;
  endfunction

  // stage 4: source point
  logic           s4_valid_r;
  pwb_pkg::item_t s4_item_r;
  logic [SW-1:0]  s4_sx_r, s4_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= dvx_v && dvy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item_r <= tagx[TXW-2:0];
      s4_sx_r   <= fold(qx, rnzx, rmx, tagx[TXW-1], mx, px, mirror);
      s4_sy_r   <= fold(qy, rnzy, rmy, tagy[0], my, py, mirror);
    end
  end

  // stage 5: frame store access
  logic [CW-1:0] lft, rgt, lp1;
  logic [RW-1:0] tp, bot, tp1;
  logic          wr_ok;

  always_comb begin
    lft   = CW'(s4_sx_r[SW-1:FW]);
    tp    = RW'(s4_sy_r[SW-1:FW]);
    lp1   = lft + CW'(1);
    tp1   = tp + RW'(1);
    rgt   = (lp1 < w_c) ? lp1 : lft;
    bot   = (tp1 < h_c) ? tp1 : tp;
    wr_ok = s4_valid_r && (s4_item_r.action == pwb_pkg::ACT_WRITE)
            && (32'(s4_item_r.pos_x) < MAX_WIDTH) && (32'(s4_item_r.pos_y) < MAX_HEIGHT);
  end

  logic [pwb_pkg::PIX_W-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = ((b % 2) == 1);
    localparam logic BY = ((b / 2) == 1);
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          we_b;
    logic [AW-1:0] addr;

    always_comb begin
      if (s4_item_r.action == pwb_pkg::ACT_WRITE) begin
        col  = CW'(s4_item_r.pos_x);
        row  = RW'(s4_item_r.pos_y);
        we_b = wr_ok && (s4_item_r.pos_x[0] == BX) && (s4_item_r.pos_y[0] == BY);
      end else begin
        col  = (lft[0] == BX) ? lft : rgt;
        row  = (tp[0] == BY) ? tp : bot;
        we_b = 1'b0;
      end
      addr = AW'(32'(row >> 1) * HW + 32'(col >> 1));
    end

    pwb_ram #(.WIDTH(pwb_pkg::PIX_W), .DEPTH(BDEPTH)) u_bank (
      .clk, .en(adv), .we(we_b), .addr(addr), .wdata(s4_item_r.rgb), .rdata(rd[b])
    );
  end

  logic          s5_valid_r, s5_warp_r, s5_fault_r;
  logic [FW-1:0] s5_fx_r, s5_fy_r;
  logic          s5_lp_r, s5_rp_r, s5_tp_r, s5_bp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_warp_r  <= (s4_item_r.action == pwb_pkg::ACT_WARP);
      s5_fault_r <= s4_item_r.fault;
      s5_fx_r    <= s4_sx_r[FW-1:0];
      s5_fy_r    <= s4_sy_r[FW-1:0];
      s5_lp_r    <= lft[0];
      s5_rp_r    <= rgt[0];
      s5_tp_r    <= tp[0];
      s5_bp_r    <= bot[0];
    end
  end

  function automatic logic [pwb_pkg::PIX_W-1:0] pick(input logic rp, input logic cp,
                                                     input logic [pwb_pkg::PIX_W-1:0] d0,
                                                     input logic [pwb_pkg::PIX_W-1:0] d1,
                                                     input logic [pwb_pkg::PIX_W-1:0] d2,
                                                     input logic [pwb_pkg::PIX_W-1:0] d3);
    logic [pwb_pkg::PIX_W-1:0] res;
    case ({rp, cp})
      2'b00:   res = d0;
      2'b01:   res = d1;
      2'b10:   res = d2;
      default: res = d3;
    endcase
    return res;
  endfunction

  // stage 6: horizontal blend
  logic [pwb_pkg::PIX_W-1:0] ptl, ptr, pbl, pbr;
  logic [FW:0]               wx0, wx1;
  logic [TVW-1:0]            tv_c [3];
  logic [TVW-1:0]            bv_c [3];

  always_comb begin
    ptl = pick(s5_tp_r, s5_lp_r, rd[0], rd[1], rd[2], rd[3]);
    ptr = pick(s5_tp_r, s5_rp_r, rd[0], rd[1], rd[2], rd[3]);
    pbl = pick(s5_bp_r, s5_lp_r, rd[0], rd[1], rd[2], rd[3]);
    pbr = pick(s5_bp_r, s5_rp_r, rd[0], rd[1], rd[2], rd[3]);
    wx1 = {1'b0, s5_fx_r};
    wx0 = (FW+1)'(ONE) - wx1;
    for (int c = 0; c < 3; c++) begin
      tv_c[c] = TVW'(ptl[8*(2-c) +: 8]) * TVW'(wx0) + TVW'(ptr[8*(2-c) +: 8]) * TVW'(wx1);
      bv_c[c] = TVW'(pbl[8*(2-c) +: 8]) * TVW'(wx0) + TVW'(pbr[8*(2-c) +: 8]) * TVW'(wx1);
    end
  end

  logic           s6_valid_r, s6_warp_r, s6_fault_r;
  logic [FW-1:0]  s6_fy_r;
  logic [TVW-1:0] s6_tv_r [3];
  logic [TVW-1:0] s6_bv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_warp_r  <= s5_warp_r;
      s6_fault_r <= s5_fault_r;
      s6_fy_r    <= s5_fy_r;
      s6_tv_r    <= tv_c;
      s6_bv_r    <= bv_c;
    end
  end

  // stage 7: vertical blend, round, output register
  logic [FW:0]   wy0, wy1;
  logic [VW-1:0] v_c [3];
  logic [7:0]    ch_c [3];

  always_comb begin
    wy1 = {1'b0, s6_fy_r};
    wy0 = (FW+1)'(ONE) - wy1;
    for (int c = 0; c < 3; c++) begin
      v_c[c]  = VW'(s6_tv_r[c]) * VW'(wy0) + VW'(s6_bv_r[c]) * VW'(wy1)
                + (VW'(1) << (2*FRAC_BITS-1));
      ch_c[c] = s6_fault_r ? 8'd0 : 8'(v_c[c] >> (2*FRAC_BITS));
    end
  end

  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s6_valid_r && s6_warp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_r   <= ch_c[0];
      out_green_r <= ch_c[1];
      out_blue_r  <= ch_c[2];
      out_fault_r <= s6_fault_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_red     = out_red_r;
  assign out_ch.out_green   = out_green_r;
  assign out_ch.out_blue    = out_blue_r;
  assign out_ch.depth_fault = out_fault_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_fault_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.depth_fault) |->
      (out_ch.out_red == 8'd0 && out_ch.out_green == 8'd0 && out_ch.out_blue == 8'd0))
    else $error("depth fault with nonzero pixel");

  a_reset_clears_output: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule
